@@ hw/rtl/nva_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package nva_pkg;

  localparam int VOICES_DEF = 6;
  localparam int NOTE_W     = 7;

  // cmd field codes
  localparam logic CMD_PRESS   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic capture;  // latch the incoming request
    logic append;   // add held note, load its result
    logic remove;   // drop matched note, compact list
    logic emit;     // load result for current voice index
  } nva_cmd_t;

  typedef struct packed {
    logic is_off;     // latched request is a release
    logic hit;        // latched note is in the list
    logic full;       // every slot in use
    logic slot_free;  // output register can take a result this cycle
    logic emit_last;  // current voice index is the final one
  } nva_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/note_voice_allocator.sv @@
// Sequence: a press is answered through a compare and then, once the output register
//   is free, a load of it; a release gives its first result through compare, compact
//   and load, and one result per cycle after that while the consumer keeps up.
// Flow: one request at a time; a new request is taken only once the previous one
//   is finished.
// Reset: synchronous rst empties the list, zeroes every slot and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
module note_voice_allocator #(
  parameter int VOICES = nva_pkg::VOICES_DEF,
  parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      cmd,
  input  wire logic [nva_pkg::NOTE_W-1:0] note,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [VW-1:0]                  voice,
  output logic [nva_pkg::NOTE_W-1:0]     voice_note,
  output logic                           voice_on,
  output logic                           last
);
  import nva_pkg::*;

  nva_cmd_t  ctl;
  nva_stat_t st;

  nva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd_o    (ctl)
  );

  nva_dp #(
    .VOICES (VOICES),
    .VW     (VW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .note       (note),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .voice      (voice),
    .voice_note (voice_note),
    .voice_on   (voice_on),
    .last       (last),
    .cmd_i      (ctl),
    .st         (st)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_append_legal: assert property (@(posedge clk) disable iff (rst)
    ctl.append |-> !st.full && !st.hit)
    else $error("append into full list or of a held note");

  a_remove_legal: assert property (@(posedge clk) disable iff (rst)
    ctl.remove |-> st.hit && st.is_off)
    else $error("remove without a matching held note");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && st.emit_last |=> in_ready && out_valid && last)
    else $error("final voice report did not close the release");

endmodule
`default_nettype wire

@@ hw/rtl/nva_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nva_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire nva_pkg::nva_stat_t st,
  output nva_pkg::nva_cmd_t      cmd_o
);
  import nva_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_o      = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_next    = S_LOOK;
        end
      end
      S_LOOK: begin
        if (st.is_off) begin
          state_next = st.hit ? S_REMOVE : S_IDLE;
        end else begin
          state_next = (st.full || st.hit) ? S_IDLE : S_APPEND;
        end
      end
      S_APPEND: begin
        if (st.slot_free) begin
          cmd_o.append = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (st.slot_free) begin
          cmd_o.emit = 1'b1;
          if (st.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/nva_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nva_dp #(
  parameter int VOICES = nva_pkg::VOICES_DEF,
  parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cmd,
  input  wire logic [nva_pkg::NOTE_W-1:0] note,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [VW-1:0]                  voice,
  output logic [nva_pkg::NOTE_W-1:0]     voice_note,
  output logic                           voice_on,
  output logic                           last,
  input  wire nva_pkg::nva_cmd_t         cmd_i,
  output nva_pkg::nva_stat_t             st
);
  import nva_pkg::*;

  localparam int CW = $clog2(VOICES + 1);

  logic              is_off;
  logic [NOTE_W-1:0] note_q;
  logic [NOTE_W-1:0] held [VOICES];
  logic [CW-1:0]     count;
  logic [VW-1:0]     idx;
  logic [VOICES-1:0] match;
  logic [VW-1:0]     pos;
  logic              idx_on;

  // parallel compare against the live part of the list
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      match[i] = (CW'(i) < count) && (held[i] == note_q);
    end
    pos = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = VW'(i);
      end
    end
  end

  assign idx_on = CW'(idx) < count;

  assign st.is_off    = (is_off == CMD_RELEASE);
  assign st.hit       = |match;
  assign st.full      = (count == CW'(VOICES));
  assign st.slot_free = !out_valid || out_ready;
  assign st.emit_last = (idx == VW'(VOICES - 1));

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      is_off <= cmd;
      note_q <= note;
    end
  end

  // slots at and above the count are kept at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        held[i] <= '0;
      end
    end else begin
      for (int i = 0; i < VOICES; i++) begin
        if (cmd_i.append && count == CW'(i)) begin
          held[i] <= note_q;
        end else if (cmd_i.remove && VW'(i) >= pos) begin
          held[i] <= (i + 1 < VOICES) ? held[(i + 1) % VOICES] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd_i.append) begin
        count <= count + CW'(1);
      end else if (cmd_i.remove) begin
        count <= count - CW'(1);
      end
      if (cmd_i.remove) begin
        idx <= '0;
      end else if (cmd_i.emit) begin
        idx <= idx + VW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_i.append || cmd_i.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.append) begin
      voice      <= count[VW-1:0];
      voice_note <= note_q;
      voice_on   <= 1'b1;
      last       <= 1'b1;
    end else if (cmd_i.emit) begin
      voice      <= idx;
      voice_note <= idx_on ? held[idx] : '0;
      voice_on   <= idx_on;
      last       <= st.emit_last;
    end
  end

endmodule
`default_nettype wire
